[rtl/mma_pkg.sv]
// ----------------------------------------------------------------------------
// mma_pkg
// Shared widths, types and constants for the multi-angle aligner.
// ----------------------------------------------------------------------------
package mma_pkg;

    localparam int LANE_FIELDS = 8;
    localparam int ANG_W       = 18;
    localparam int CNT_W       = 4;
    localparam int IV_W        = 17;
    localparam int OUT_W       = 32;
    localparam int LRES_W      = 19;   // aligned lane value, within ref +/- interval/2
    localparam int SUM_W       = 22;

    localparam logic [IV_W-1:0] IV_RESET = 17'd18432;

    typedef logic signed [ANG_W-1:0]  t_angle;
    typedef logic signed [LRES_W-1:0] t_lres;

    typedef struct packed {
        logic signed [OUT_W-1:0] angle;
        logic                    err;
        logic                    sat;
    } t_merge_res;

endpackage

[rtl/mma_if.sv]
// ----------------------------------------------------------------------------
// mma_if
// Valid/ready channels carrying input and result beats.
// ----------------------------------------------------------------------------
interface mma_in_if;
    import mma_pkg::*;

    logic             valid;
    logic             ready;
    t_angle           angle_lane_0;
    t_angle           angle_lane_1;
    t_angle           angle_lane_2;
    t_angle           angle_lane_3;
    t_angle           angle_lane_4;
    t_angle           angle_lane_5;
    t_angle           angle_lane_6;
    t_angle           angle_lane_7;
    logic [CNT_W-1:0] lane_count;

    modport source (output valid, angle_lane_0, angle_lane_1, angle_lane_2, angle_lane_3,
                    angle_lane_4, angle_lane_5, angle_lane_6, angle_lane_7, lane_count,
                    input ready);
    modport sink   (input valid, angle_lane_0, angle_lane_1, angle_lane_2, angle_lane_3,
                    angle_lane_4, angle_lane_5, angle_lane_6, angle_lane_7, lane_count,
                    output ready);
endinterface

interface mma_out_if;
    import mma_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] aligned_angle;
    logic                    empty_error;
    logic                    saturated;

    modport source (output valid, aligned_angle, empty_error, saturated, input ready);
    modport sink   (input valid, aligned_angle, empty_error, saturated, output ready);
endinterface

[rtl/multi_angle_align_unwrap_top.sv]
// Each accepted beat runs one divide in every lane, then two divides in the merge
//   stage (mean, then unwrap), with handshake stages between.
// One beat in flight at a time: input reopens once the result is registered,
//   and a stalled result beat holds the next one in the output stage.
// A zero lane count or the first non-empty beat after reset skips the merge divides.
// Reset (synchronous, active low) clears history, interval to 72 degrees, and
//   empties the output register.
// ----------------------------------------------------------------------------
// multi_angle_align_unwrap_top
// Parallel lane aligners feeding an averaging and unwrapping merge stage.
// ----------------------------------------------------------------------------
module multi_angle_align_unwrap_top #(
    parameter int MAX_LANES = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [mma_pkg::IV_W-1:0] i_cfg_wdata,
    mma_in_if.sink                   i_in_if,
    mma_out_if.source                o_out_if
);
    import mma_pkg::*;

    localparam int NLANE = (MAX_LANES < LANE_FIELDS) ? MAX_LANES : LANE_FIELDS;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_LANE  = 4'b0010,
        S_MERGE = 4'b0100,
        S_OUT   = 4'b1000
    } t_state;

    t_state           r_state;
    logic [IV_W-1:0]  r_iv;
    t_angle           r_ang [LANE_FIELDS];
    logic [CNT_W-1:0] r_cnt;
    logic             r_lane_start;
    logic             r_merge_start;
    logic             r_ov;
    t_merge_res       r_out;

    logic             accept;
    logic [NLANE-1:0] lane_done;
    t_lres            lane_res [NLANE];
    logic             merge_done;
    t_merge_res       merge_res;
    logic             load_out;

    assign accept   = i_in_if.valid && i_in_if.ready;
    assign load_out = (r_state == S_OUT) && (!r_ov || o_out_if.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_iv          <= IV_RESET;
            r_lane_start  <= 1'b0;
            r_merge_start <= 1'b0;
            r_ov          <= 1'b0;
        end else begin
            r_lane_start  <= 1'b0;
            r_merge_start <= 1'b0;
            if (i_cfg_we)
                r_iv <= i_cfg_wdata;
            if (load_out)
                r_ov <= 1'b1;
            else if (o_out_if.ready)
                r_ov <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_lane_start <= 1'b1;
                        r_state      <= S_LANE;
                    end
                end
                S_LANE: begin
                    // all lanes run in lock step
                    if (&lane_done) begin
                        r_merge_start <= 1'b1;
                        r_state       <= S_MERGE;
                    end
                end
                S_MERGE: if (merge_done) r_state <= S_OUT;
                S_OUT:   if (load_out) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ang[0] <= i_in_if.angle_lane_0;
            r_ang[1] <= i_in_if.angle_lane_1;
            r_ang[2] <= i_in_if.angle_lane_2;
            r_ang[3] <= i_in_if.angle_lane_3;
            r_ang[4] <= i_in_if.angle_lane_4;
            r_ang[5] <= i_in_if.angle_lane_5;
            r_ang[6] <= i_in_if.angle_lane_6;
            r_ang[7] <= i_in_if.angle_lane_7;
            r_cnt    <= (i_in_if.lane_count > CNT_W'(NLANE)) ? CNT_W'(NLANE)
                                                              : i_in_if.lane_count;
        end
        if (load_out)
            r_out <= merge_res;
    end

    for (genvar g = 0; g < NLANE; g++) begin : g_lane
        mma_lane u_lane (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_start(r_lane_start),
            .i_x    (r_ang[g]),
            .i_ref  (r_ang[0]),
            .i_iv   (r_iv),
            .o_done (lane_done[g]),
            .o_res  (lane_res[g])
        );
    end

    mma_merge #(.NL(NLANE)) u_merge (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_merge_start),
        .i_cnt  (r_cnt),
        .i_iv   (r_iv),
        .i_lane (lane_res),
        .o_done (merge_done),
        .o_res  (merge_res)
    );

    assign i_in_if.ready          = (r_state == S_IDLE);
    assign o_out_if.valid         = r_ov;
    assign o_out_if.aligned_angle = r_out.angle;
    assign o_out_if.empty_error   = r_out.err;
    assign o_out_if.saturated     = r_out.sat;
endmodule

[rtl/mma_div.sv]
// ----------------------------------------------------------------------------
// mma_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mma_div #(
    parameter int NW = 21,
    parameter int DW = 18
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quo
);
    localparam int CW = $clog2(NW + 1);

    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [DW-1:0] r_rem;
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_den;

    logic [DW:0]   t;
    logic [DW:0]   t_sub;
    logic          ge;

    assign t     = {r_rem, r_quo[NW-1]};
    assign t_sub = t - {1'b0, r_den};
    assign ge    = (t >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? t_sub[DW-1:0] : t[DW-1:0];
            r_quo <= {r_quo[NW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

[rtl/mma_lane.sv]
// ----------------------------------------------------------------------------
// mma_lane
// Shifts one tracker angle by a whole number of intervals to sit nearest
// the reference lane.
// ----------------------------------------------------------------------------
module mma_lane (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  mma_pkg::t_angle          i_x,
    input  mma_pkg::t_angle          i_ref,
    input  logic [mma_pkg::IV_W-1:0] i_iv,
    output logic                     o_done,
    output mma_pkg::t_lres           o_res
);
    import mma_pkg::*;

    localparam int NUM_W = LRES_W + 2;

    typedef enum logic [2:0] {
        L_IDLE = 3'b001,
        L_DIV  = 3'b010,
        L_MUL  = 3'b100
    } t_lstate;

    t_lstate r_state;
    t_angle  r_x;
    logic [IV_W-1:0] r_iv;
    logic    r_neg;
    logic    r_done;
    t_lres   r_res;
    logic signed [39:0] r_prod;

    t_lres             diff;
    logic [LRES_W-1:0] mag;
    logic [NUM_W-1:0]  num;
    logic              div_done;
    logic [NUM_W-1:0]  quo;
    logic signed [NUM_W:0] n_q;
    logic signed [IV_W:0]  ivs;
    logic signed [39:0]    full;

    assign diff = LRES_W'(i_x) - LRES_W'(i_ref);
    assign mag  = diff[LRES_W-1] ? LRES_W'(-diff) : LRES_W'(diff);
    assign num  = {1'b0, mag, 1'b0} + NUM_W'(i_iv);

    mma_div #(.NW(NUM_W), .DW(IV_W + 1)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_start),
        .i_num  (num),
        .i_den  ({i_iv, 1'b0}),
        .o_done (div_done),
        .o_quo  (quo)
    );

    always_comb begin
        if (r_iv == '0)
            n_q = '0;
        else if (r_neg)
            n_q = -$signed({1'b0, quo});
        else
            n_q = $signed({1'b0, quo});
    end

    assign ivs  = $signed({1'b0, r_iv});
    assign full = 40'(r_x) - r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                L_IDLE: if (i_start) r_state <= L_DIV;
                L_DIV:  if (div_done) r_state <= L_MUL;
                L_MUL: begin
                    r_done  <= 1'b1;
                    r_state <= L_IDLE;
                end
                default: r_state <= L_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_x;
            r_iv  <= i_iv;
            r_neg <= diff[LRES_W-1];
        end
        if (r_state == L_DIV && div_done)
            r_prod <= n_q * ivs;
        if (r_state == L_MUL)
            r_res <= $signed(full[LRES_W-1:0]);
    end

    assign o_done = r_done;
    assign o_res  = r_res;
endmodule

[rtl/mma_merge.sv]
// ----------------------------------------------------------------------------
// mma_merge
// Averages the aligned lanes and unwraps the mean against the last output.
// ----------------------------------------------------------------------------
module mma_merge #(
    parameter int NL = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [mma_pkg::CNT_W-1:0] i_cnt,
    input  logic [mma_pkg::IV_W-1:0]  i_iv,
    input  mma_pkg::t_lres            i_lane [NL],
    output logic                      o_done,
    output mma_pkg::t_merge_res       o_res
);
    import mma_pkg::*;

    localparam int NUM_W  = OUT_W + 3;
    localparam int MEAN_W = SUM_W + 1;
    localparam int DIFF_W = OUT_W + 2;
    localparam int PROD_W = NUM_W + IV_W + 2;

    typedef enum logic [5:0] {
        M_IDLE  = 6'b000001,
        M_SUM   = 6'b000010,
        M_MEAN  = 6'b000100,
        M_DIFF  = 6'b001000,
        M_ALIGN = 6'b010000,
        M_MUL   = 6'b100000
    } t_mstate;

    t_mstate r_state;
    logic signed [OUT_W-1:0]  r_last;
    logic                     r_has_last;
    logic signed [SUM_W-1:0]  r_sum;
    logic [CNT_W-1:0]         r_cnt;
    logic signed [MEAN_W-1:0] r_mean;
    logic                     r_neg;
    logic signed [PROD_W-1:0] r_prod;
    t_merge_res               r_res;
    logic                     r_done;

    logic signed [SUM_W-1:0]  sum;
    logic [SUM_W-1:0]         sum_mag;
    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]        diff_mag;
    logic                     div_start;
    logic [NUM_W-1:0]         div_num;
    logic [IV_W:0]            div_den;
    logic                     div_done;
    logic [NUM_W-1:0]         quo;
    logic signed [NUM_W:0]    q_s;
    logic signed [IV_W:0]     ivs;
    logic signed [PROD_W-1:0] res;
    logic signed [PROD_W-1:0] max_v;
    logic signed [PROD_W-1:0] min_v;

    always_comb begin
        sum = '0;
        for (int i = 0; i < NL; i++) begin
            if (CNT_W'(i) < i_cnt)
                sum = sum + SUM_W'(i_lane[i]);
        end
    end

    assign sum_mag  = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign diff     = DIFF_W'(r_mean) - DIFF_W'(r_last);
    assign diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        case (r_state)
            M_SUM: begin
                div_start = 1'b1;
                div_num   = NUM_W'({sum_mag, 1'b0}) + NUM_W'(r_cnt);
                div_den   = (IV_W + 1)'({r_cnt, 1'b0});
            end
            M_DIFF: begin
                div_start = 1'b1;
                div_num   = NUM_W'({diff_mag, 1'b0}) + NUM_W'(i_iv);
                div_den   = {i_iv, 1'b0};
            end
            default: ;
        endcase
    end

    mma_div #(.NW(NUM_W), .DW(IV_W + 1)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (div_num),
        .i_den  (div_den),
        .o_done (div_done),
        .o_quo  (quo)
    );

    assign q_s   = r_neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    assign ivs   = $signed({1'b0, i_iv});
    assign res   = PROD_W'(r_mean) - r_prod;
    assign max_v = PROD_W'({1'b0, {(OUT_W-1){1'b1}}});
    assign min_v = PROD_W'($signed({1'b1, {(OUT_W-1){1'b0}}}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= M_IDLE;
            r_done     <= 1'b0;
            r_last     <= '0;
            r_has_last <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                M_IDLE: begin
                    if (i_start) begin
                        if (i_cnt == '0) begin
                            r_res  <= '{angle: r_last, err: 1'b1, sat: 1'b0};
                            r_done <= 1'b1;
                        end else if (!r_has_last) begin
                            // first beat: lane 0 passes straight through
                            r_res      <= '{angle: OUT_W'(i_lane[0]), err: 1'b0, sat: 1'b0};
                            r_last     <= OUT_W'(i_lane[0]);
                            r_has_last <= 1'b1;
                            r_done     <= 1'b1;
                        end else begin
                            r_sum   <= sum;
                            r_cnt   <= i_cnt;
                            r_state <= M_SUM;
                        end
                    end
                end
                M_SUM: begin
                    r_neg   <= r_sum[SUM_W-1];
                    r_state <= M_MEAN;
                end
                M_MEAN: begin
                    if (div_done) begin
                        r_mean  <= MEAN_W'(q_s);
                        r_state <= M_DIFF;
                    end
                end
                M_DIFF: begin
                    r_neg   <= diff[DIFF_W-1];
                    r_state <= M_ALIGN;
                end
                M_ALIGN: begin
                    if (div_done) begin
                        if (i_iv == '0)
                            r_prod <= '0;
                        else
                            r_prod <= q_s * ivs;
                        r_state <= M_MUL;
                    end
                end
                M_MUL: begin
                    if (res > max_v) begin
                        r_res  <= '{angle: max_v[OUT_W-1:0], err: 1'b0, sat: 1'b1};
                        r_last <= max_v[OUT_W-1:0];
                    end else if (res < min_v) begin
                        r_res  <= '{angle: min_v[OUT_W-1:0], err: 1'b0, sat: 1'b1};
                        r_last <= min_v[OUT_W-1:0];
                    end else begin
                        r_res  <= '{angle: res[OUT_W-1:0], err: 1'b0, sat: 1'b0};
                        r_last <= res[OUT_W-1:0];
                    end
                    r_done  <= 1'b1;
                    r_state <= M_IDLE;
                end
                default: r_state <= M_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;
endmodule

[rtl/mma_checker.sv]
// ----------------------------------------------------------------------------
// mma_checker
// Port-level checks on the aligner's channels, bound to the top level.
// ----------------------------------------------------------------------------
module mma_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_err,
    input logic i_out_sat
);
    // a held result beat stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    // one beat in flight: input closes right after acceptance
    a_one_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input accepted twice in a row");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_out_err && i_out_sat))
        else $error("empty and saturated both set");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");
endmodule

bind multi_angle_align_unwrap_top mma_checker u_mma_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_if.valid),
    .i_in_ready (i_in_if.ready),
    .i_out_valid(o_out_if.valid),
    .i_out_ready(o_out_if.ready),
    .i_out_err  (o_out_if.empty_error),
    .i_out_sat  (o_out_if.saturated)
);

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives lane-angle beats into the aligner and unwraps them in a software
// predictor with 64-bit arithmetic. Every result beat is checked against the
// oldest prediction. The interval register steps through several settings,
// its extremes among them, with random stalls on both channels.
// ----------------------------------------------------------------------------
import mma_pkg::*;

typedef struct {
    t_angle            lane [LANE_FIELDS];
    logic [CNT_W-1:0]  cnt;
} t_lane_beat;

typedef struct {
    logic signed [OUT_W-1:0] angle;
    logic                    err;
    logic                    sat;
} t_unwrap_res;

class unwrap_scoreboard;
    localparam int N_LANES = 8;

    t_unwrap_res       pending_q [$];
    logic [IV_W-1:0]   interval;
    longint            prev_angle;
    bit                have_prev;
    int                n_errors;

    function new();
        interval   = IV_RESET;
        prev_angle = 0;
        have_prev  = 0;
        n_errors   = 0;
    endfunction

    function void set_interval(logic [IV_W-1:0] v);
        interval = v;
    endfunction

    // nearest integer, halves away from zero
    function longint round_div(longint a, longint b);
        if (a >= 0) return (2 * a + b) / (2 * b);
        return -((-2 * a + b) / (2 * b));
    endfunction

    function longint wrap_near(longint v, longint anchor, longint iv);
        if (iv == 0) return v;
        return v - round_div(v - anchor, iv) * iv;
    endfunction

    function void note_beat(t_lane_beat b);
        int          n;
        longint      iv, base, acc, res;
        t_unwrap_res e;
        n  = int'(b.cnt);
        iv = longint'(interval);
        if (n > N_LANES) n = N_LANES;
        if (n == 0) begin
            e.angle = prev_angle[OUT_W-1:0];
            e.err   = 1'b1;
            e.sat   = 1'b0;
            pending_q.push_back(e);
            return;
        end
        base = longint'(b.lane[0]);
        if (!have_prev) begin
            res = base;
        end else begin
            acc = base;
            for (int i = 1; i < n; i++)
                acc += wrap_near(longint'(b.lane[i]), base, iv);
            res = wrap_near(round_div(acc, n), prev_angle, iv);
        end
        e.sat = 1'b0;
        if (res > 64'sd2147483647) begin
            res   = 64'sd2147483647;
            e.sat = 1'b1;
        end else if (res < -64'sd2147483648) begin
            res   = -64'sd2147483648;
            e.sat = 1'b1;
        end
        prev_angle = res;
        have_prev  = 1;
        e.angle    = res[OUT_W-1:0];
        e.err      = 1'b0;
        pending_q.push_back(e);
    endfunction

    task report(string msg);
        $display("mismatch: %s", msg);
        n_errors++;
    endtask

    task check_result(logic signed [OUT_W-1:0] a, logic er, logic st);
        t_unwrap_res e;
        if (pending_q.size() == 0) begin
            report($sformatf("unexpected result angle=%0d", a));
            return;
        end
        e = pending_q.pop_front();
        if (a !== e.angle)
            report($sformatf("aligned_angle got %0d want %0d", a, e.angle));
        if (er !== e.err)
            report($sformatf("empty_error got %b want %b", er, e.err));
        if (st !== e.sat)
            report($sformatf("saturated got %b want %b", st, e.sat));
    endtask
endclass

module tb_top;
    localparam int     CYCLE_LIMIT = 2000000;
    localparam int     RAND_PER_PHASE = 250;
    localparam int     ANG_MAX = 92160;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [IV_W-1:0]   i_cfg_wdata = '0;
    bit                calm = 0;
    int                cycles = 0;
    unwrap_scoreboard  sb = new();
    logic [IV_W-1:0]   cur_iv = IV_RESET;

    mma_in_if  in_ch ();
    mma_out_if out_ch ();

    multi_angle_align_unwrap_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_if     (in_ch),
        .o_out_if    (out_ch)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.angle_lane_0 = '0; in_ch.angle_lane_1 = '0;
        in_ch.angle_lane_2 = '0; in_ch.angle_lane_3 = '0;
        in_ch.angle_lane_4 = '0; in_ch.angle_lane_5 = '0;
        in_ch.angle_lane_6 = '0; in_ch.angle_lane_7 = '0;
        in_ch.lane_count = '0;
        out_ch.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // result sink: random back-pressure
    always @(negedge i_clk) begin
        if (!i_rst_n) out_ch.ready <= 1'b0;
        else out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 36);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.aligned_angle, out_ch.empty_error, out_ch.saturated);
    end

    // called just after a falling edge; returns just after a falling edge
    task automatic send_beat(t_lane_beat b);
        while (!calm && $urandom_range(99) < 36) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid = 1'b1;
        in_ch.angle_lane_0 = b.lane[0]; in_ch.angle_lane_1 = b.lane[1];
        in_ch.angle_lane_2 = b.lane[2]; in_ch.angle_lane_3 = b.lane[3];
        in_ch.angle_lane_4 = b.lane[4]; in_ch.angle_lane_5 = b.lane[5];
        in_ch.angle_lane_6 = b.lane[6]; in_ch.angle_lane_7 = b.lane[7];
        in_ch.lane_count = b.cnt;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_beat(b);
        @(negedge i_clk);
        in_ch.valid = 1'b0;
    endtask

    task automatic drain();
        while (sb.pending_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_interval(logic [IV_W-1:0] v);
        drain();
        repeat (20) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = v;
        sb.set_interval(v);
        cur_iv = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic t_angle clip_angle(longint v);
        if (v > ANG_MAX) v = ANG_MAX;
        if (v < -ANG_MAX) v = -ANG_MAX;
        return t_angle'(v);
    endfunction

    function automatic t_lane_beat fill_beat(longint a0, longint step, int n);
        t_lane_beat b;
        for (int i = 0; i < LANE_FIELDS; i++)
            b.lane[i] = clip_angle(a0 + i * step);
        b.cnt = CNT_W'(n);
        return b;
    endfunction

    function automatic t_lane_beat random_beat();
        t_lane_beat b;
        longint     base, k;
        int         pick;
        pick = $urandom_range(99);
        base = longint'($urandom_range(2 * ANG_MAX)) - ANG_MAX;
        for (int i = 0; i < LANE_FIELDS; i++) begin
            if (pick < 12) begin
                // full 18-bit range, outside the nominal span too
                b.lane[i] = t_angle'($urandom);
            end else begin
                // same target seen at another symmetry position, with jitter
                k = longint'($urandom_range(4)) - 2;
                b.lane[i] = clip_angle(base + k * longint'(cur_iv)
                                       + longint'($urandom_range(512)) - 256);
            end
        end
        if (pick < 80)      b.cnt = CNT_W'($urandom_range(8, 1));
        else if (pick < 90) b.cnt = '0;
        else                b.cnt = CNT_W'($urandom_range(15, 9));
        return b;
    endfunction

    initial begin
        logic [IV_W-1:0] iv_plan [6];
        t_lane_beat      b;
        iv_plan = '{17'd1, 17'd92160, 17'd0, 17'h1FFFF, IV_RESET,
                    IV_RESET};
        iv_plan[5] = IV_W'($urandom_range(92160, 2));

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: empty before history, first beat, extremes, clamped counts
        send_beat(fill_beat(0, 0, 0));
        send_beat(fill_beat(ANG_MAX, 0, 3));
        send_beat(fill_beat(0, 0, 0));
        send_beat(fill_beat(-ANG_MAX, 0, 8));
        send_beat(fill_beat(ANG_MAX, -ANG_MAX / 4, 8));
        send_beat(fill_beat(-ANG_MAX, ANG_MAX / 4, 15));
        send_beat(fill_beat(9216, 18432, 9));
        send_beat(fill_beat(-9216, -18432, 1));
        send_beat(fill_beat(9216, 0, 2));
        send_beat(fill_beat(100, 18432, 8));
        b = fill_beat(0, 0, 8);
        b.lane[0] = 18'sh1FFFF; b.lane[1] = 18'sh20000;
        b.lane[2] = 18'sh20000; b.lane[3] = 18'sh1FFFF;
        send_beat(b);
        b.lane[0] = 18'sh20000;
        send_beat(b);
        send_beat(fill_beat(0, 0, 0));
        send_beat(fill_beat(1, 1, 4));
        send_beat(fill_beat(-1, -1, 5));
        send_beat(fill_beat(36864, 9216, 6));

        for (int p = 0; p < 7; p++) begin
            if (p > 0) write_interval(iv_plan[p - 1]);
            if (p == 0) begin
                // zero interval with directed beats: no shifting at all
                write_interval(17'd0);
                send_beat(fill_beat(ANG_MAX, -ANG_MAX / 3, 8));
                send_beat(fill_beat(-ANG_MAX, 1, 7));
                write_interval(IV_RESET);
            end
            for (int i = 0; i < RAND_PER_PHASE; i++) begin
                calm = (p == 3 && i >= 40 && i < 200);
                send_beat(random_beat());
            end
            calm = 0;
        end

        drain();
        repeat (150) @(posedge i_clk);
        if (sb.n_errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end
endmodule

[multi_angle_align_unwrap_top.f]
rtl/mma_pkg.sv
rtl/mma_if.sv
rtl/mma_div.sv
rtl/mma_lane.sv
rtl/mma_merge.sv
rtl/multi_angle_align_unwrap_top.sv
rtl/mma_checker.sv
sim/tb_top.sv
